// File: rtl/core/u2a_pkg.sv
// Package for the UTF-8 to ASCII folder: shared types, constants and fold tables.
// Used by u2a_front, u2a_queue and utf8_to_ascii_folder_unit.
package u2a_pkg;

    localparam int MAX_CHARS = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [6:0] CH_QMARK = 7'h3f;
    localparam logic [6:0] CH_SPACE = 7'h20;

    // first character of each table sits in the top byte
    localparam logic [767:0] LATIN1_TAB = {
        " !????|???a\"????", "o?23'u?.,1o\"????", "AAAAAA?CEEEEIIII",
        "DNOOOOOxOUUUUY??", "aaaaaa?ceeeeiiii", "dnooooo/ouuuuy?y"};

    localparam logic [1023:0] LATIN_EXT_TAB = {
        "AaAaAaCcCcCcCcDd", "DdEeEeEeEeEeGgGg", "GgGgHhHhIiIiIiIi",
        "Ii??JjKkkLlLlLlL", "lLlNnNnNnnNnOoOo", "Oo??RrRrRrSsSsSs",
        "SsTtTtTtUuUuUuUu", "UuUuWwYyYZzZzZzs"};

    // one queue entry: up to four characters and a count
    typedef struct packed {
        logic [2:0]       count;
        logic [3:0][6:0]  chars;
    } run_t;

    function automatic logic [6:0] latin1_fold(input logic [6:0] idx);
        logic [6:0] rev;
        rev = 7'd95 - idx;
        return LATIN1_TAB[{rev, 3'b000} +: 7];
    endfunction

    function automatic logic [6:0] latin_ext_fold(input logic [6:0] idx);
        logic [6:0] rev;
        rev = 7'd127 - idx;
        return LATIN_EXT_TAB[{rev, 3'b000} +: 7];
    endfunction

    function automatic logic is_invisible(input logic [20:0] c);
        return c == 21'h00ad || (c >= 21'h0300 && c <= 21'h036f)
            || (c >= 21'h200b && c <= 21'h200f) || (c >= 21'h202a && c <= 21'h202e)
            || (c >= 21'h2060 && c <= 21'h206f) || (c >= 21'hfe00 && c <= 21'hfe0f)
            || c == 21'hfeff;
    endfunction

    function automatic logic [6:0] ascii_twin(input logic [20:0] c);
        if ((c >= 21'h2000 && c <= 21'h200a) || c == 21'h202f || c == 21'h205f
            || c == 21'h3000)
            return 7'h20;
        if ((c >= 21'h2010 && c <= 21'h2015) || c == 21'h2212)
            return 7'h2d;
        if ((c >= 21'h2018 && c <= 21'h201b) || c == 21'h2032 || c == 21'h2039
            || c == 21'h203a)
            return 7'h27;
        if ((c >= 21'h201c && c <= 21'h201f) || c == 21'h2033)
            return 7'h22;
        return CH_QMARK;
    endfunction

    function automatic run_t fold_code(input logic [20:0] c);
        run_t r;
        r.count = 3'd1;
        r.chars = '0;
        if (c < 21'h80) begin
            r.chars[0] = (c < 21'h20 || c == 21'h7f) ? CH_SPACE : c[6:0];
        end
        else if (c < 21'ha0) begin
            r.chars[0] = CH_SPACE;
        end
        else if (is_invisible(c)) begin
            r.count = 3'd0;
        end
        else begin
            r.count = 3'd2;
            case (c)
                21'h00c6: r.chars[1:0] = {7'h45, 7'h41};
                21'h00de: r.chars[1:0] = {7'h48, 7'h54};
                21'h00df: r.chars[1:0] = {7'h73, 7'h73};
                21'h00e6: r.chars[1:0] = {7'h65, 7'h61};
                21'h00fe: r.chars[1:0] = {7'h68, 7'h74};
                21'h0132: r.chars[1:0] = {7'h4a, 7'h49};
                21'h0133: r.chars[1:0] = {7'h6a, 7'h69};
                21'h0152: r.chars[1:0] = {7'h45, 7'h4f};
                21'h0153: r.chars[1:0] = {7'h65, 7'h6f};
                21'h2026:
                begin
                    r.count = 3'd3;
                    r.chars[2:0] = {7'h2e, 7'h2e, 7'h2e};
                end
                default:
                begin
                    r.count = 3'd1;
                    if (c <= 21'hff)
                        r.chars[0] = latin1_fold(7'(c - 21'ha0));
                    else if (c <= 21'h17f)
                        r.chars[0] = latin_ext_fold(c[6:0]);
                    else
                        r.chars[0] = ascii_twin(c);
                end
            endcase
        end
        return r;
    endfunction

endpackage

// File: rtl/core/u2a_front.sv
// Front end: accepts bytes, runs the UTF-8 decoder state and folds code points
// into runs of characters. Depends on u2a_pkg.
module u2a_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            push,
    output u2a_pkg::run_t   run
);

    logic [20:0] partial_reg, partial_next;
    logic [2:0]  needed_reg, needed_next;
    logic [2:0]  held_reg, held_next;

    always_comb
    begin
        logic [20:0] c;
        logic [20:0] shortest;
        logic        fresh;
        logic [2:0]  pre;
        u2a_pkg::run_t f;
        partial_next = partial_reg;
        needed_next = needed_reg;
        held_next = held_reg;
        run.count = 3'd0;
        run.chars = {4{u2a_pkg::CH_QMARK}};
        fresh = 1'b0;
        pre = 3'd0;
        c = '0;
        shortest = '0;
        f = '0;
        if (needed_reg != 3'd0) begin
            if (in_byte[7:6] == 2'b10) begin
                c = {partial_reg[14:0], in_byte[5:0]};
                partial_next = c;
                held_next = held_reg + 3'd1;
                if (held_next >= needed_reg) begin
                    shortest = (needed_reg == 3'd2) ? 21'h80 :
                               (needed_reg == 3'd3) ? 21'h800 : 21'h10000;
                    partial_next = '0;
                    needed_next = 3'd0;
                    held_next = 3'd0;
                    if (c < shortest || c > 21'h10ffff || (c >= 21'hd800 && c <= 21'hdfff))
                        run.count = held_reg + 3'd1;
                    else
                        run = u2a_pkg::fold_code(c);
                end
                else if (in_last) begin
                    run.count = held_next;
                    partial_next = '0;
                    needed_next = 3'd0;
                    held_next = 3'd0;
                end
            end
            else begin
                pre = held_reg;
                fresh = 1'b1;
                partial_next = '0;
                needed_next = 3'd0;
                held_next = 3'd0;
            end
        end
        else begin
            fresh = 1'b1;
        end
        if (fresh) begin
            if (!in_byte[7]) begin
                f = u2a_pkg::fold_code({14'd0, in_byte[6:0]});
                run.count = pre + f.count;
                if (f.count != 3'd0)
                    run.chars[pre[1:0]] = f.chars[0];
            end
            else if (in_byte >= 8'hc2 && in_byte <= 8'hf4) begin
                needed_next = (in_byte < 8'he0) ? 3'd2 : (in_byte < 8'hf0) ? 3'd3 : 3'd4;
                partial_next = (in_byte < 8'he0) ? {16'd0, in_byte[4:0]} :
                               (in_byte < 8'hf0) ? {17'd0, in_byte[3:0]} :
                                                   {18'd0, in_byte[2:0]};
                held_next = 3'd1;
                run.count = pre;
                if (in_last) begin
                    run.count = pre + 3'd1;
                    partial_next = '0;
                    needed_next = 3'd0;
                    held_next = 3'd0;
                end
            end
            else begin
                run.count = pre + 3'd1;
            end
        end
    end

    assign push = in_valid && (run.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            partial_reg <= '0;
            needed_reg <= '0;
            held_reg <= '0;
        end
        else if (in_valid) begin
            partial_reg <= partial_next;
            needed_reg <= needed_next;
            held_reg <= held_next;
        end
    end

endmodule

// File: rtl/core/u2a_queue.sv
// Run queue between decoder front end and character back end.
// Depends on u2a_pkg.
module u2a_queue #(
    parameter int DEPTH = u2a_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u2a_pkg::run_t   push_run,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output u2a_pkg::run_t   head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    u2a_pkg::run_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full = cnt_reg == (AW+1)'(DEPTH);
    assign empty = cnt_reg == '0;
    assign head = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + AW'(1);
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// File: rtl/core/utf8_to_ascii_folder_unit.sv
// Top level of the UTF-8 to ASCII folder: front end, run queue, character emitter.
// Depends on u2a_pkg, u2a_front and u2a_queue.
//
// Slave channel s_axis: one UTF-8 byte per word, tuser flags the string's last byte.
// Master channel m_axis: one printable ASCII character per word, tlast marks the
// last character of the run pushed for one input byte. Bytes that only extend a
// sequence or fold to an invisible mark produce no word.
// The decoder folds a byte in the cycle it is accepted and pushes its run of
// one to four characters, if any, into a small queue; the emitter sends one
// character per cycle from the head run while the receiver is ready. Throughput
// is one byte per cycle while the receiver is ready and each byte yields at most
// one character; a byte yielding several characters holds the output for each,
// so the output character rate (one per cycle) sets the sustained byte rate.
// s_axis_tready drops only when the queue is full; a stalled receiver holds
// the current character and the queue fills, then input stalls.
// Reset clears the decoder state and the queue; no partial sequence survives.
module utf8_to_ascii_folder_unit #(
    parameter int QUEUE_DEPTH = u2a_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic        m_axis_tlast
);

    logic          push, full, empty, pop;
    u2a_pkg::run_t run, head;
    logic [1:0]    idx_reg;

    assign s_axis_tready = !full;

    u2a_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid && s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tuser),
        .push     (push),
        .run      (run)
    );

    u2a_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (run),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    assign m_axis_tvalid = !empty;
    assign m_axis_tdata = {1'b0, head.chars[idx_reg]};
    assign m_axis_tlast = ({1'b0, idx_reg} + 3'd1) == head.count;
    assign pop = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (m_axis_tvalid && m_axis_tready)
            idx_reg <= m_axis_tlast ? 2'd0 : idx_reg + 2'd1;
    end

endmodule
